// ===== rtl/settings_record_checker_top_macros.svh =====
// Assertion macros for the settings record checker.
// Each macro expects clk_i in the scope where it is used; SETREC_ASSERT also expects rst_ni.
`ifndef SETTINGS_RECORD_CHECKER_TOP_MACROS_SVH
`define SETTINGS_RECORD_CHECKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SETREC_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("settings record checker assertion failed");
`define SETREC_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("settings record checker assertion failed");
`else
`define SETREC_ASSERT(label, prop)
`define SETREC_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/setrec_pkg.sv =====
package setrec_pkg;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BAD_MAGIC   = 2'd1,
    STATUS_BAD_VERSION = 2'd2,
    STATUS_BAD_CRC     = 2'd3
  } status_e;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [7:0] MAGIC_FIRST  = 8'h41;
  localparam logic [7:0] MAGIC_SECOND = 8'h44;
  localparam logic [7:0] RECORD_VER   = 8'h01;

  localparam logic [7:0] RATE_MAX    = 8'd2;
  localparam logic [7:0] LEVEL_MAX   = 8'd10;
  localparam logic [7:0] FILTER_MAX  = 8'd7;

  localparam logic [1:0] RATE_DEFAULT   = 2'd0;
  localparam logic [3:0] LEVEL_DEFAULT  = 4'd5;
  localparam logic [2:0] FILTER_DEFAULT = 3'd2;

  localparam logic [3:0] POS_MAGIC_FIRST  = 4'd0;
  localparam logic [3:0] POS_MAGIC_SECOND = 4'd1;
  localparam logic [3:0] POS_VERSION      = 4'd2;
  localparam logic [3:0] POS_RATE         = 4'd3;
  localparam logic [3:0] POS_CHANNEL      = 4'd4;
  localparam logic [3:0] POS_KEY          = 4'd5;
  localparam logic [3:0] POS_DISPLAY      = 4'd6;
  localparam logic [3:0] POS_FILTER       = 4'd7;
  localparam logic [3:0] POS_CRC_LOW      = 4'd14;
  localparam logic [3:0] POS_LAST         = 4'd15;
  localparam logic [3:0] CRC_SPAN         = 4'd14;

  // One byte of CRC-16/CCITT, MSB first, no reflection.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/setrec_if.sv =====
interface setrec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte;

  modport source (output valid, output record_byte, input ready);
  modport sink   (input valid, input record_byte, output ready);
endinterface

interface setrec_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [1:0] rate_index;
  logic       second_channel_on;
  logic [3:0] key_brightness;
  logic [3:0] display_brightness;
  logic [2:0] filter_index;

  modport source (
    output valid, output status, output rate_index, output second_channel_on,
    output key_brightness, output display_brightness, output filter_index,
    input ready
  );
  modport sink (
    input valid, input status, input rate_index, input second_channel_on,
    input key_brightness, input display_brightness, input filter_index,
    output ready
  );
endinterface

// ===== rtl/settings_record_checker_top.sv =====
// The result beat is registered and appears in the cycle after the 16th byte of a record is accepted.
// Throughput: one byte per cycle; the byte-wide CRC update is combinational logic.
// A byte is held back only when it ends a record and the previous result is still waiting.
// Reset is asynchronous and active low; it clears the byte count, the CRC, the check flags
// and the output valid flag, so the checker starts at byte 0 of a new record.
`include "settings_record_checker_top_macros.svh"

module settings_record_checker_top import setrec_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  setrec_in_if.sink     rec_i,
  setrec_out_if.source  res_o
);

  logic [3:0]  pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic        magic_q, magic_d;
  logic        version_q, version_d;

  logic [7:0]  rate_q;
  logic        chan_q;
  logic [7:0]  key_q;
  logic [7:0]  disp_q;
  logic [7:0]  filt_q;
  logic [7:0]  crc_low_q;

  logic        out_valid_q;
  status_e     status_q, status_d;
  logic [1:0]  rate_idx_q;
  logic        chan_on_q;
  logic [3:0]  key_br_q;
  logic [3:0]  disp_br_q;
  logic [2:0]  filt_idx_q;

  logic        in_fire;
  logic        out_fire;
  logic        last_byte;
  logic [7:0]  in_byte;
  logic [15:0] stored_crc;

  assign in_byte    = rec_i.record_byte;
  assign last_byte  = (pos_q == POS_LAST);
  assign in_fire    = rec_i.valid && rec_i.ready;
  assign out_fire   = out_valid_q && res_o.ready;
  assign rec_i.ready = !last_byte || !out_valid_q || res_o.ready;
  assign stored_crc = {in_byte, crc_low_q};

  always_comb begin
    pos_d     = pos_q;
    crc_d     = crc_q;
    magic_d   = magic_q;
    version_d = version_q;
    if (in_fire) begin
      if (last_byte) begin
        pos_d     = '0;
        crc_d     = CRC_INIT;
        magic_d   = 1'b1;
        version_d = 1'b1;
      end else begin
        pos_d = pos_q + 4'd1;
        if (pos_q < CRC_SPAN) begin
          crc_d = crc_byte(crc_q, in_byte);
        end
        unique case (pos_q)
          POS_MAGIC_FIRST: begin
            if (in_byte != MAGIC_FIRST) magic_d = 1'b0;
          end
          POS_MAGIC_SECOND: begin
            if (in_byte != MAGIC_SECOND) magic_d = 1'b0;
          end
          POS_VERSION: begin
            if (in_byte != RECORD_VER) version_d = 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    if (!magic_q) begin
      status_d = STATUS_BAD_MAGIC;
    end else if (!version_q) begin
      status_d = STATUS_BAD_VERSION;
    end else if (stored_crc != crc_q) begin
      status_d = STATUS_BAD_CRC;
    end else begin
      status_d = STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      crc_q       <= CRC_INIT;
      magic_q     <= 1'b1;
      version_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      magic_q   <= magic_d;
      version_q <= version_d;
      if (in_fire && last_byte) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      unique case (pos_q)
        POS_RATE:    rate_q    <= in_byte;
        POS_CHANNEL: chan_q    <= (in_byte != 8'd0);
        POS_KEY:     key_q     <= in_byte;
        POS_DISPLAY: disp_q    <= in_byte;
        POS_FILTER:  filt_q    <= in_byte;
        POS_CRC_LOW: crc_low_q <= in_byte;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && last_byte) begin
      status_q <= status_d;
      if (status_d == STATUS_OK) begin
        rate_idx_q <= (rate_q > RATE_MAX) ? RATE_DEFAULT : rate_q[1:0];
        chan_on_q  <= chan_q;
        key_br_q   <= (key_q > LEVEL_MAX) ? LEVEL_MAX[3:0] : key_q[3:0];
        disp_br_q  <= (disp_q > LEVEL_MAX) ? LEVEL_MAX[3:0] : disp_q[3:0];
        filt_idx_q <= (filt_q > FILTER_MAX) ? 3'd0 : filt_q[2:0];
      end else begin
        rate_idx_q <= RATE_DEFAULT;
        chan_on_q  <= 1'b0;
        key_br_q   <= LEVEL_DEFAULT;
        disp_br_q  <= LEVEL_DEFAULT;
        filt_idx_q <= FILTER_DEFAULT;
      end
    end
  end

  assign res_o.valid              = out_valid_q;
  assign res_o.status             = status_q;
  assign res_o.rate_index         = rate_idx_q;
  assign res_o.second_channel_on  = chan_on_q;
  assign res_o.key_brightness     = key_br_q;
  assign res_o.display_brightness = disp_br_q;
  assign res_o.filter_index       = filt_idx_q;

  `SETREC_ASSERT(a_result_follows_last_byte,
    $rose(out_valid_q) |-> $past(in_fire && last_byte))
  `SETREC_ASSERT(a_rearm_after_record,
    (in_fire && last_byte) |=> (pos_q == 4'd0 && crc_q == CRC_INIT && magic_q && version_q))
  `SETREC_ASSERT(a_failed_record_defaults,
    (out_valid_q && status_q != STATUS_OK) |-> (rate_idx_q == RATE_DEFAULT && !chan_on_q && key_br_q == LEVEL_DEFAULT && disp_br_q == LEVEL_DEFAULT && filt_idx_q == FILTER_DEFAULT))
  `SETREC_ASSERT(a_good_record_in_range,
    (out_valid_q && status_q == STATUS_OK) |-> (rate_idx_q <= RATE_MAX[1:0] && key_br_q <= LEVEL_MAX[3:0] && disp_br_q <= LEVEL_MAX[3:0]))
  `SETREC_ASSERT_ALWAYS(a_reset_clears_valid,
    !rst_ni |=> !out_valid_q)

endmodule

// ===== bench/tb_settings_record_checker_top.sv =====
`timescale 1ns / 100ps

module tb_settings_record_checker_top;
  import setrec_pkg::*;

  typedef struct packed {
    status_e    status;
    logic [1:0] rate;
    logic       channel;
    logic [3:0] key;
    logic [3:0] display;
    logic [2:0] filter;
  } settings_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  setrec_in_if  rec_if ();
  setrec_out_if res_if ();

  settings_record_checker_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rec_i  (rec_if),
    .res_o  (res_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  settings_t   pending_settings_q[$];
  int          fail_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          hold_req = 0;
  int          hold_left = 0;
  logic [7:0]  rec_buf [16];

  logic [3:0]  rec_pos = 4'd0;
  logic [15:0] rec_crc = CRC_INIT;
  logic        magic_ok = 1'b1;
  logic        version_ok = 1'b1;
  logic [7:0]  kept_rate = 8'd0;
  logic        kept_channel = 1'b0;
  logic [7:0]  kept_key = 8'd0;
  logic [7:0]  kept_display = 8'd0;
  logic [7:0]  kept_filter = 8'd0;
  logic [7:0]  kept_crc_low = 8'd0;

  // Bit-serial form of the CRC-16/CCITT register, one data bit per shift.
  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] data);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ data[i];
      crc = {crc[14:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    settings_t   want;
    logic [15:0] stored;
    if (rec_pos < CRC_SPAN) begin
      rec_crc = crc_update(rec_crc, b);
    end
    case (rec_pos)
      POS_MAGIC_FIRST: begin
        if (b != MAGIC_FIRST) magic_ok = 1'b0;
      end
      POS_MAGIC_SECOND: begin
        if (b != MAGIC_SECOND) magic_ok = 1'b0;
      end
      POS_VERSION: begin
        if (b != RECORD_VER) version_ok = 1'b0;
      end
      POS_RATE:    kept_rate = b;
      POS_CHANNEL: kept_channel = (b != 8'd0);
      POS_KEY:     kept_key = b;
      POS_DISPLAY: kept_display = b;
      POS_FILTER:  kept_filter = b;
      POS_CRC_LOW: kept_crc_low = b;
      default: ;
    endcase
    if (rec_pos != POS_LAST) begin
      rec_pos = rec_pos + 4'd1;
    end else begin
      stored = {b, kept_crc_low};
      if (!magic_ok) begin
        want.status = STATUS_BAD_MAGIC;
      end else if (!version_ok) begin
        want.status = STATUS_BAD_VERSION;
      end else if (stored != rec_crc) begin
        want.status = STATUS_BAD_CRC;
      end else begin
        want.status = STATUS_OK;
      end
      if (want.status == STATUS_OK) begin
        want.rate    = (kept_rate > RATE_MAX) ? 2'd0 : kept_rate[1:0];
        want.channel = kept_channel;
        want.key     = (kept_key > LEVEL_MAX) ? LEVEL_MAX[3:0] : kept_key[3:0];
        want.display = (kept_display > LEVEL_MAX) ? LEVEL_MAX[3:0] : kept_display[3:0];
        want.filter  = (kept_filter > FILTER_MAX) ? 3'd0 : kept_filter[2:0];
      end else begin
        want.rate    = RATE_DEFAULT;
        want.channel = 1'b0;
        want.key     = LEVEL_DEFAULT;
        want.display = LEVEL_DEFAULT;
        want.filter  = FILTER_DEFAULT;
      end
      pending_settings_q.push_back(want);
      rec_pos    = 4'd0;
      rec_crc    = CRC_INIT;
      magic_ok   = 1'b1;
      version_ok = 1'b1;
    end
  endtask

  // Entered at a falling edge; returns at the falling edge after the beat.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      rec_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rec_if.valid       <= 1'b1;
    rec_if.record_byte <= b;
    do begin
      @(posedge clk_i);
    end while (!rec_if.ready);
    predict_byte(b);
    @(negedge clk_i);
  endtask

  task automatic send_record();
    for (int i = 0; i < 16; i++) begin
      send_byte(rec_buf[i]);
    end
  endtask

  task automatic seal_record();
    logic [15:0] crc;
    crc = CRC_INIT;
    for (int i = 0; i < 14; i++) begin
      crc = crc_update(crc, rec_buf[i]);
    end
    rec_buf[14] = crc[7:0];
    rec_buf[15] = crc[15:8];
  endtask

  task automatic build_good_record(input logic [7:0] rate, input logic [7:0] channel,
                                   input logic [7:0] key, input logic [7:0] display,
                                   input logic [7:0] filter);
    rec_buf[0] = MAGIC_FIRST;
    rec_buf[1] = MAGIC_SECOND;
    rec_buf[2] = RECORD_VER;
    rec_buf[3] = rate;
    rec_buf[4] = channel;
    rec_buf[5] = key;
    rec_buf[6] = display;
    rec_buf[7] = filter;
    for (int i = 8; i < 14; i++) begin
      rec_buf[i] = 8'($urandom);
    end
    seal_record();
  endtask

  // Mostly small values around every clamp limit, sometimes all ones or anything.
  function automatic logic [7:0] pick_setting();
    int r;
    r = $urandom_range(9);
    if (r < 6) begin
      return 8'($urandom_range(12));
    end else if (r == 6) begin
      return 8'hFF;
    end
    return 8'($urandom);
  endfunction

  task automatic build_random_record();
    int mix;
    mix = $urandom_range(99);
    build_good_record(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                      pick_setting());
    if (mix >= 90) begin
      for (int i = 0; i < 16; i++) begin
        rec_buf[i] = 8'($urandom);
      end
    end else if (mix >= 60) begin
      if (mix < 70 || $urandom_range(3) == 0) begin
        rec_buf[4'($urandom_range(1))] ^= 8'($urandom_range(1, 255));
      end
      if ((mix >= 70 && mix < 80) || $urandom_range(3) == 0) begin
        rec_buf[POS_VERSION] ^= 8'($urandom_range(1, 255));
      end
      if ($urandom_range(1) == 1) begin
        seal_record();
      end
      if (mix >= 80 || $urandom_range(3) == 0) begin
        rec_buf[4'($urandom_range(3, 15))] ^= 8'($urandom_range(1, 255));
      end
    end
  endtask

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    settings_t got;
    settings_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      got.status  = status_e'(res_if.status);
      got.rate    = res_if.rate_index;
      got.channel = res_if.second_channel_on;
      got.key     = res_if.key_brightness;
      got.display = res_if.display_brightness;
      got.filter  = res_if.filter_index;
      if (pending_settings_q.size() == 0) begin
        report_failure("Result beat arrived with no record pending.");
      end else begin
        want = pending_settings_q.pop_front();
        if (got.status !== want.status || got.rate !== want.rate ||
            got.channel !== want.channel || got.key !== want.key ||
            got.display !== want.display || got.filter !== want.filter) begin
          report_failure($sformatf({"Settings mismatch: expected st %0d rate %0d ch %0d ",
            "key %0d disp %0d filt %0d, got st %0d rate %0d ch %0d key %0d disp %0d ",
            "filt %0d"}, want.status, want.rate, want.channel, want.key, want.display,
            want.filter, got.status, got.rate, got.channel, got.key, got.display,
            got.filter));
        end
      end
    end
  end

  task automatic test_clamp_limits();
    build_good_record(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_record();
  endtask

  task automatic test_fault_priority();
    build_good_record(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    rec_buf[POS_MAGIC_FIRST] = 8'h00;
    rec_buf[POS_VERSION]     = 8'hFF;
    send_record();
    rec_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic test_random_traffic();
    int idle_pct [4]  = '{0, 59, 0, 37};
    int stall_pct [4] = '{0, 0, 59, 37};
    for (int stage = 0; stage < 4; stage++) begin
      sender_idle_pct    = idle_pct[stage];
      receiver_stall_pct = stall_pct[stage];
      repeat (8) begin
        build_random_record();
        send_record();
      end
    end
    rec_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // The output is held off long enough that the block must stall its input.
  task automatic test_output_hold_off();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    @(posedge clk_i);
    hold_req = 300;
    @(negedge clk_i);
    repeat (4) begin
      build_good_record(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                        pick_setting());
      send_record();
    end
    rec_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    rst_ni             = 1'b0;
    rec_if.valid       = 1'b0;
    rec_if.record_byte = 8'd0;
    res_if.ready       = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_clamp_limits();
    test_fault_priority();
    test_random_traffic();
    test_output_hold_off();
    receiver_stall_pct = 0;
    wait (pending_settings_q.size() == 0);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("FAIL");
    $finish;
  end

endmodule
